// ===== rtl/scle_pkg.sv =====
`default_nettype none
package scle_pkg;

    // Default length of the line store.
    localparam int LINE_LEN_DEF = 64;

    // Character codes that the editor reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_LBR   = 8'h5B;

    // Kind of an output beat.
    typedef enum logic [1:0] {
        K_ECHO = 2'd0,
        K_LINE = 2'd1,
        K_MARK = 2'd2
    } t_kind;

    // Echo sequence selected by a received byte.
    typedef enum logic [1:0] {
        E_NONE,
        E_BS_DEL,
        E_BS_EMPTY,
        E_ARROW
    } t_echo;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_RD,
        S_LINE,
        S_MARK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // byte accepted that does not end the line
        logic start;      // byte accepted that ends the line
        logic rd;         // read the line store at the sequence index
        logic emit_echo;  // load the next echo byte into the output register
        logic emit_line;  // load the read line byte into the output register
        logic emit_mark;  // load the empty-line marker into the output register
        logic clear;      // clear the line state
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic line_end;   // the byte on the input ends the line
        logic will_echo;  // the byte on the input causes an echo
        logic empty;      // nothing is stored
        logic echo_last;  // the sequence index is on the last echo byte
        logic line_last;  // the sequence index is on the last stored byte
        logic slot_free;  // the output register can take a beat
    } t_dp_stat;

    // Number of bytes in an echo sequence.
    function automatic logic [2:0] echo_len(input t_echo code);
        logic [2:0] len;
        unique case (code)
            E_BS_DEL:   len = 3'd3;
            E_BS_EMPTY: len = 3'd4;
            E_ARROW:    len = 3'd6;
            default:    len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte of an echo sequence at a given position.
    function automatic logic [7:0] echo_byte(input t_echo code, input logic [2:0] idx,
                                             input logic [7:0] opp);
        logic [7:0] b;
        b = CH_BEL;
        unique case (code)
            E_BS_DEL: begin
                unique case (idx)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = CH_LBR;
                    default: b = CH_P;
                endcase
            end
            E_BS_EMPTY: begin
                unique case (idx)
                    3'd0:    b = CH_SPACE;
                    3'd1:    b = CH_ESC;
                    3'd2:    b = CH_LBR;
                    default: b = CH_BEL;
                endcase
            end
            E_ARROW: begin
                unique case (idx)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = CH_LBR;
                    3'd2:    b = opp;
                    3'd3:    b = CH_ESC;
                    3'd4:    b = CH_LBR;
                    default: b = CH_BEL;
                endcase
            end
            default: b = CH_BEL;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/scle_rx_if.sv =====
`default_nettype none
interface scle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/scle_tx_if.sv =====
`default_nettype none
interface scle_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/scle_ram.sv =====
`default_nettype none
module scle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = scle_pkg::LINE_LEN_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/scle_ctrl.sv =====
`default_nettype none
module scle_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rx_valid,
    output logic                    o_rx_ready,
    input  wire scle_pkg::t_dp_stat i_stat,
    output scle_pkg::t_dp_cmd       o_cmd
);

    scle_pkg::t_state r_state;
    scle_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b0;
        unique case (r_state)
            scle_pkg::S_IDLE: begin
                o_rx_ready = 1'b1;
                if (i_rx_valid) begin
                    if (i_stat.line_end) begin
                        o_cmd.start = 1'b1;
                        n_state     = i_stat.empty ? scle_pkg::S_MARK : scle_pkg::S_RD;
                    end else begin
                        o_cmd.take = 1'b1;
                        if (i_stat.will_echo) begin
                            n_state = scle_pkg::S_ECHO;
                        end
                    end
                end
            end
            scle_pkg::S_ECHO: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_echo = 1'b1;
                    if (i_stat.echo_last) begin
                        n_state = scle_pkg::S_IDLE;
                    end
                end
            end
            scle_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = scle_pkg::S_LINE;
            end
            scle_pkg::S_LINE: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_line = 1'b1;
                    if (i_stat.line_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = scle_pkg::S_IDLE;
                    end else begin
                        n_state = scle_pkg::S_RD;
                    end
                end
            end
            scle_pkg::S_MARK: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_mark = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_state         = scle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scle_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/scle_dp.sv =====
`default_nettype none
module scle_dp #(
    parameter int LINE_LEN = scle_pkg::LINE_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_rx_byte,
    input  wire scle_pkg::t_dp_cmd i_cmd,
    output scle_pkg::t_dp_stat     o_stat,
    input  wire logic              i_tx_ready,
    output logic                   o_tx_valid,
    output logic [1:0]             o_tx_kind,
    output logic [7:0]             o_tx_data,
    output logic                   o_tx_last
);

    localparam int IdxW  = $clog2(LINE_LEN);
    localparam int FillW = $clog2(LINE_LEN + 1);
    localparam int SeqW  = (IdxW > 3) ? IdxW : 3;

    logic [FillW-1:0]     r_fill, n_fill;
    logic [7:0]           r_prev, n_prev;
    logic                 r_esc, n_esc;
    scle_pkg::t_echo      r_echo, n_echo;
    logic [7:0]           r_opp, n_opp;
    logic [SeqW-1:0]      r_seq, n_seq;
    logic                 r_out_valid, n_out_valid;
    scle_pkg::t_kind      r_out_kind, n_out_kind;
    logic [7:0]           r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;

    // Decode of the byte on the input.
    logic                 d_store;
    logic                 d_esc_set;
    logic                 d_esc_clr;
    logic                 d_dec;
    scle_pkg::t_echo      d_echo;
    logic [7:0]           d_opp;
    logic [7:0]           ram_rdata;
    logic                 slot_free;
    logic                 echo_last;
    logic                 line_last;

    always_comb begin
        d_store   = 1'b0;
        d_esc_set = 1'b0;
        d_esc_clr = 1'b0;
        d_dec     = 1'b0;
        d_echo    = scle_pkg::E_NONE;
        d_opp     = scle_pkg::CH_B;
        unique case (i_rx_byte)
            scle_pkg::CH_LF, scle_pkg::CH_ESC: begin
                d_store = 1'b0;
            end
            scle_pkg::CH_BS: begin
                if (r_fill != '0) begin
                    d_echo = scle_pkg::E_BS_DEL;
                    d_dec  = 1'b1;
                end else begin
                    d_echo = scle_pkg::E_BS_EMPTY;
                end
            end
            scle_pkg::CH_LBR: begin
                if (r_prev == scle_pkg::CH_ESC) begin
                    d_esc_set = 1'b1;
                end else begin
                    d_store = 1'b1;
                end
            end
            scle_pkg::CH_A, scle_pkg::CH_C, scle_pkg::CH_D: begin
                if (r_esc) begin
                    d_echo    = scle_pkg::E_ARROW;
                    d_esc_clr = 1'b1;
                    if (i_rx_byte == scle_pkg::CH_A) begin
                        d_opp = scle_pkg::CH_B;
                    end else if (i_rx_byte == scle_pkg::CH_C) begin
                        d_opp = scle_pkg::CH_D;
                    end else begin
                        d_opp = scle_pkg::CH_C;
                    end
                end else begin
                    d_store = 1'b1;
                end
            end
            scle_pkg::CH_B: begin
                d_store = !r_esc;
            end
            default: begin
                d_store = 1'b1;
            end
        endcase
    end

    // Status towards the controller.
    assign slot_free = !r_out_valid || i_tx_ready;
    assign echo_last = (r_seq[2:0] == (scle_pkg::echo_len(r_echo) - 3'd1));
    assign line_last = ((FillW'(r_seq) + FillW'(1)) == r_fill);

    always_comb begin
        o_stat.line_end  = (r_fill == FillW'(LINE_LEN)) || (i_rx_byte == scle_pkg::CH_NUL)
                           || (i_rx_byte == scle_pkg::CH_CR);
        o_stat.will_echo = (d_echo != scle_pkg::E_NONE);
        o_stat.empty     = (r_fill == '0);
        o_stat.echo_last = echo_last;
        o_stat.line_last = line_last;
        o_stat.slot_free = slot_free;
    end

    // Line store.
    scle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && d_store),
        .i_waddr (r_fill[IdxW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_seq[IdxW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Line state, sequence index and output register.
    always_comb begin
        n_fill      = r_fill;
        n_prev      = r_prev;
        n_esc       = r_esc;
        n_echo      = r_echo;
        n_opp       = r_opp;
        n_seq       = r_seq;
        n_out_valid = r_out_valid && !i_tx_ready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (i_cmd.take) begin
            n_prev = i_rx_byte;
            n_echo = d_echo;
            n_opp  = d_opp;
            n_seq  = '0;
            if (d_store) begin
                n_fill = r_fill + FillW'(1);
            end else if (d_dec) begin
                n_fill = r_fill - FillW'(1);
            end
            if (d_esc_set) begin
                n_esc = 1'b1;
            end else if (d_esc_clr) begin
                n_esc = 1'b0;
            end
        end
        if (i_cmd.start) begin
            n_seq = '0;
        end
        if (i_cmd.emit_echo) begin
            n_out_valid = 1'b1;
            n_out_kind  = scle_pkg::K_ECHO;
            n_out_data  = scle_pkg::echo_byte(r_echo, r_seq[2:0], r_opp);
            n_out_last  = echo_last;
            n_seq       = r_seq + SeqW'(1);
        end
        if (i_cmd.emit_line) begin
            n_out_valid = 1'b1;
            n_out_kind  = scle_pkg::K_LINE;
            n_out_data  = ram_rdata;
            n_out_last  = line_last;
            n_seq       = r_seq + SeqW'(1);
        end
        if (i_cmd.emit_mark) begin
            n_out_valid = 1'b1;
            n_out_kind  = scle_pkg::K_MARK;
            n_out_data  = 8'd0;
            n_out_last  = 1'b1;
        end
        if (i_cmd.clear) begin
            n_fill = '0;
            n_prev = scle_pkg::CH_NUL;
            n_esc  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_prev      <= scle_pkg::CH_NUL;
            r_esc       <= 1'b0;
            r_echo      <= scle_pkg::E_NONE;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_prev      <= n_prev;
            r_esc       <= n_esc;
            r_echo      <= n_echo;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_opp      <= n_opp;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_tx_valid = r_out_valid;
    assign o_tx_kind  = r_out_kind;
    assign o_tx_data  = r_out_data;
    assign o_tx_last  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/serial_console_line_editor_top.sv =====
// Channel   Direction  Payload                         Beat
// i_rx      in         rx_byte[7:0]                    one received console byte
// o_tx      out        kind[1:0], data[7:0], last      one echo byte, line byte or marker
//
// A byte that causes no output leaves the block ready again; an echoing byte is followed by its echo bytes.
// A line end runs through S_RD and S_LINE by turns, set by the registered read of the line store:
// each stored byte is read in S_RD and loaded into the output register in S_LINE.
// An empty line end accepts the byte, then loads the marker into the output register in S_MARK.
// A new byte is accepted only once every beat of the previous one is in the output register.
// Reset is synchronous and active low; it empties the line without touching the store.
// A stall on o_tx holds the output register and the sequencer until the beat is taken.
`default_nettype none
module serial_console_line_editor_top #(
    parameter int LINE_LEN = scle_pkg::LINE_LEN_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scle_rx_if.sink   i_rx,
    scle_tx_if.source o_tx
);

    scle_pkg::t_dp_cmd  cmd;
    scle_pkg::t_dp_stat stat;

    // Sequencer.
    scle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Line state, line store and output register.
    scle_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_tx_ready (o_tx.ready),
        .o_tx_valid (o_tx.valid),
        .o_tx_kind  (o_tx.kind),
        .o_tx_data  (o_tx.data),
        .o_tx_last  (o_tx.last)
    );

    // An empty-line marker is always the final beat of its byte.
    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && (o_tx.kind == scle_pkg::K_MARK)) |-> o_tx.last)
        else $error("empty-line marker without last");

    // The kind code never takes the unused value.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx.valid |-> ((o_tx.kind == scle_pkg::K_ECHO) || (o_tx.kind == scle_pkg::K_LINE)
                        || (o_tx.kind == scle_pkg::K_MARK)))
        else $error("invalid kind on output");

    // A newline that does not end a full line is dropped, so the block is ready again
    // in the next cycle.
    a_lf_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx.valid && i_rx.ready && (i_rx.rx_byte == scle_pkg::CH_LF) && !stat.line_end)
        |=> i_rx.ready)
        else $error("newline started output work");

    // A backspace always starts output work, so the block is busy in the next cycle.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx.valid && i_rx.ready && (i_rx.rx_byte == scle_pkg::CH_BS)) |=> !i_rx.ready)
        else $error("backspace did not start an echo");

endmodule
`default_nettype wire

// ===== sim/tb_serial_console_line_editor_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_serial_console_line_editor_top;

    localparam int LINE_LEN    = scle_pkg::LINE_LEN_DEF;
    localparam int IDX_W       = $clog2(LINE_LEN);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 2 * LINE_LEN + 8;

    // One output beat as the editor should present it.
    typedef struct packed {
        scle_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_beat;

    // A directed row: the byte, and where the answer is obvious, the beats typed in.
    typedef struct {
        logic [7:0]      b;
        bit              typed;
        scle_pkg::t_kind k;
        string           seq;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    scle_rx_if rx_ch();
    scle_tx_if tx_ch();

    serial_console_line_editor_top #(
        .LINE_LEN(LINE_LEN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch),
        .o_tx   (tx_ch)
    );

    // Shadow copy of the editor's line state.
    logic [7:0] line_buf [LINE_LEN];
    logic [6:0] fill_cnt = '0;
    logic [7:0] last_rx  = '0;
    logic       in_csi   = 1'b0;

    t_beat fresh_beats[$];
    t_beat pending_beats[$];

    // What the byte being offered should produce, when typed in by hand.
    bit              cur_typed = 1'b0;
    scle_pkg::t_kind cur_kind  = scle_pkg::K_ECHO;
    string           cur_seq   = "";

    bit steady    = 1'b0;
    int hold_reqs = 0;
    int n_errors  = 0;
    int cycles    = 0;

    t_row dir_rows[$];

    // Clock generation.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void push_beat(input scle_pkg::t_kind k, input logic [7:0] d);
        fresh_beats.push_back('{kind: k, data: d, last: 1'b0});
    endfunction

    function automatic void store_rx(input logic [7:0] b);
        if (fill_cnt < LINE_LEN) begin
            line_buf[fill_cnt[IDX_W-1:0]] = b;
            fill_cnt = fill_cnt + 7'd1;
        end
    endfunction

    // Advance the shadow line state by one received byte and collect its beats.
    function automatic void edit_byte(input logic [7:0] b);
        logic [7:0] opp;
        if (fill_cnt >= LINE_LEN || b == scle_pkg::CH_NUL || b == scle_pkg::CH_CR) begin
            if (fill_cnt == 0) begin
                push_beat(scle_pkg::K_MARK, 8'h00);
            end else begin
                for (int i = 0; i < fill_cnt; i++)
                    push_beat(scle_pkg::K_LINE, line_buf[IDX_W'(i)]);
            end
            fill_cnt = '0;
            last_rx  = '0;
            in_csi   = 1'b0;
        end else begin
            unique case (b)
                scle_pkg::CH_LF, scle_pkg::CH_ESC: begin
                end
                scle_pkg::CH_BS: begin
                    if (fill_cnt != 0) begin
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_ESC);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_LBR);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_P);
                        fill_cnt = fill_cnt - 7'd1;
                    end else begin
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_SPACE);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_ESC);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_LBR);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_BEL);
                    end
                end
                scle_pkg::CH_LBR: begin
                    if (last_rx == scle_pkg::CH_ESC) in_csi = 1'b1;
                    else store_rx(b);
                end
                scle_pkg::CH_A, scle_pkg::CH_C, scle_pkg::CH_D: begin
                    if (in_csi) begin
                        opp = (b == scle_pkg::CH_A) ? scle_pkg::CH_B :
                              (b == scle_pkg::CH_C) ? scle_pkg::CH_D : scle_pkg::CH_C;
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_ESC);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_LBR);
                        push_beat(scle_pkg::K_ECHO, opp);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_ESC);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_LBR);
                        push_beat(scle_pkg::K_ECHO, scle_pkg::CH_BEL);
                        in_csi = 1'b0;
                    end else begin
                        store_rx(b);
                    end
                end
                scle_pkg::CH_B: begin
                    if (!in_csi) store_rx(b);
                end
                default: store_rx(b);
            endcase
            last_rx = b;
        end
        if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
        n_errors++;
    endtask

    task automatic check_beat();
        t_beat want;
        if (pending_beats.size() == 0) begin
            report_mismatch("beat with nothing expected", {tx_ch.kind, tx_ch.data, tx_ch.last}, 0);
        end else begin
            want = pending_beats.pop_front();
            if (tx_ch.kind !== want.kind) report_mismatch("kind", tx_ch.kind, want.kind);
            if (tx_ch.data !== want.data) report_mismatch("data", tx_ch.data, want.data);
            if (tx_ch.last !== want.last) report_mismatch("last", tx_ch.last, want.last);
        end
    endtask

    // Monitor: predict on every accepted byte, check every accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                fresh_beats.delete();
                edit_byte(rx_ch.rx_byte);
                if (!cur_typed) begin
                    foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
                end else if (cur_kind == scle_pkg::K_MARK) begin
                    pending_beats.push_back('{kind: scle_pkg::K_MARK, data: 8'h00, last: 1'b1});
                end else begin
                    for (int i = 0; i < cur_seq.len(); i++)
                        pending_beats.push_back('{kind: cur_kind, data: cur_seq[i],
                                                  last: (i == cur_seq.len() - 1)});
                end
            end
            if (tx_ch.valid && tx_ch.ready) check_beat();
        end
    end

    // Receiver: random back-pressure, with a long hold-off on request.
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        tx_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                tx_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                tx_ch.ready <= 1'b1;
            end else begin
                tx_ch.ready <= ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Offer one byte, with random gaps ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input scle_pkg::t_kind k = scle_pkg::K_ECHO,
                             input string seq = "");
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 12) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_kind  = k;
        cur_seq   = seq;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        while (!taken) begin
            @(posedge i_clk);
            taken = rx_ch.valid && rx_ch.ready;
        end
    endtask

    // Stop offering and wait until every expected beat has arrived.
    task automatic drain();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic, mostly well-formed editing with some noise mixed in.
    task automatic random_phase(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // A run of printable characters.
                len = $urandom_range(1, 6);
                repeat (len) send_byte(8'($urandom_range(8'h20, 8'h7E)));
                sent += len;
            end else if (pick < 60) begin
                // Cursor key sequence, sometimes with swallowed or stored bytes inside.
                send_byte(scle_pkg::CH_ESC);
                send_byte(scle_pkg::CH_LBR);
                len = $urandom_range(0, 2);
                repeat (len) begin
                    if ($urandom_range(0, 1)) send_byte(scle_pkg::CH_B);
                    else send_byte(8'($urandom_range(8'h61, 8'h7A)));
                end
                send_byte(scle_pkg::CH_A + 8'($urandom_range(0, 3)));
                sent += 3 + len;
            end else if (pick < 72) begin
                len = $urandom_range(1, 3);
                repeat (len) send_byte(scle_pkg::CH_BS);
                sent += len;
            end else if (pick < 84) begin
                send_byte($urandom_range(0, 1) ? scle_pkg::CH_CR : scle_pkg::CH_NUL);
                sent++;
            end else if (pick < 90) begin
                send_byte(scle_pkg::CH_LF);
                sent++;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin : stimulus
        logic [7:0] fill_b;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;

        dir_rows = '{
            '{scle_pkg::CH_CR,  1'b1, scle_pkg::K_MARK, ""},
            '{scle_pkg::CH_BS,  1'b1, scle_pkg::K_ECHO, " \033[\007"},
            '{scle_pkg::CH_NUL, 1'b1, scle_pkg::K_MARK, ""},
            '{8'hFF,            1'b0, scle_pkg::K_ECHO, ""},
            '{8'h01,            1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_A,   1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_BS,  1'b1, scle_pkg::K_ECHO, "\033[P"},
            '{scle_pkg::CH_LF,  1'b1, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_ESC, 1'b1, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_LBR, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_B,   1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_A,   1'b1, scle_pkg::K_ECHO, "\033[B\033[\007"},
            '{scle_pkg::CH_LBR, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_ESC, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_LBR, 1'b0, scle_pkg::K_ECHO, ""},
            '{"z",              1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_C,   1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_ESC, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_LBR, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_D,   1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_D,   1'b0, scle_pkg::K_ECHO, ""},
            '{8'h80,            1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_CR,  1'b0, scle_pkg::K_ECHO, ""},
            '{"q",              1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_NUL, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_ESC, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_CR,  1'b1, scle_pkg::K_MARK, ""},
            '{scle_pkg::CH_LBR, 1'b0, scle_pkg::K_ECHO, ""},
            '{scle_pkg::CH_A,   1'b0, scle_pkg::K_ECHO, ""}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: line ends, backspace, escape handling and its lifetime.
        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].k, dir_rows[i].seq);

        random_phase(6);

        // A stretch with no idling on either side, apart from the hold-off below.
        steady = 1'b1;
        random_phase(5);

        // Fill the store completely while the receiver holds off, so the editor
        // backs up; the byte after a full store ends the line and is discarded.
        hold_reqs++;
        send_byte(scle_pkg::CH_CR);
        repeat (LINE_LEN) begin
            do fill_b = 8'($urandom_range(8'h20, 8'h7E)); while (fill_b == scle_pkg::CH_LBR);
            send_byte(fill_b);
        end
        send_byte(8'($urandom_range(0, 255)));
        steady = 1'b0;
        drain();

        random_phase(5);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
